[src/stable_matching_engine_defines.svh]
// assertion macros used by the stable matching engine
`ifndef STABLE_MATCHING_ENGINE_DEFINES_SVH
`define STABLE_MATCHING_ENGINE_DEFINES_SVH

// same-cycle implication
`define SME_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sme implication check failed");

// next-cycle implication
`define SME_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sme next-cycle check failed");

// invariant at every edge
`define SME_ASSERT_ALW(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sme invariant check failed");

`endif

[src/sme_pkg.sv]
// types, codes and constants of the stable matching engine
package sme_pkg;

   localparam int ID_W              = 4;
   localparam int ID_RANGE          = 16;
   localparam int CFG_W             = 5;
   localparam int MAX_PAIRS_DEFAULT = 16;
   localparam logic [CFG_W-1:0] PAIRS_RESET = 5'd16;

   localparam logic [1:0] CMD_LOAD_SELLER = 2'd0;
   localparam logic [1:0] CMD_LOAD_BUYER  = 2'd1;
   localparam logic [1:0] CMD_RUN         = 2'd2;

   typedef struct packed {
      logic [1:0]      cmd;
      logic [ID_W-1:0] person;
      logic [ID_W-1:0] position;
      logic [ID_W-1:0] chosen;
   } sme_req_type;

   typedef struct packed {
      logic [ID_W-1:0] seller_id;
      logic [ID_W-1:0] buyer_id;
      logic            last;
   } sme_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_seller;
      logic load_buyer;
      logic run_init;
      logic scan;
      logic rank_rd;
      logic decide;
      logic next_seller;
      logic new_round;
      logic out_start;
      logic out_load;
   } sme_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eligible;
      logic buyer_ok;
      logic unmatched_zero;
      logic last_seller;
      logic proposed;
      logic out_free;
   } sme_stat_type;

endpackage

[src/stable_matching_engine.sv]
// top level of the stable matching engine
// Load-then-run stable matching (seller-proposing). Words with cmd 0 write one
// seller preference entry and words with cmd 1 write one buyer entry, which is
// stored inverted as the buyer's rank of that seller; both are taken one per
// cycle and give no result. A word with cmd 2 starts a run over pairs_in_use
// sellers and buyers (clamped to 1 .. built size): setup, then each seller
// visit passes the scan and advance states when the seller is matched or out
// of list, adds pref for a buyer out of range and rank for a full proposal,
// as the pref memory read, rank memory read and decision follow one another
// through registered memory ports. With permutation lists a run makes at most
// n*n proposals. The run then returns n result words, seller 0 first, one per
// cycle while rsp_stall is low, with last set on the final one. Requests are
// stalled from the run word until the last result has entered the output
// register. Every preference and rank entry a run reads must have been loaded.
`include "stable_matching_engine_defines.svh"

module stable_matching_engine #(
   parameter int MAX_PAIRS = sme_pkg::MAX_PAIRS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sme_pkg::sme_req_type      req_data,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sme_pkg::sme_rsp_type      rsp_data,
   // pairs_in_use register
   input  logic                      csr_wr_en,
   input  logic [sme_pkg::CFG_W-1:0] csr_wr_data
);
   import sme_pkg::*;

   sme_cmd_type  cmd;
   sme_stat_type stat;

   // state machine: handshake on the request side, sequencing of rounds
   sme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memories, per-person match state and the output register
   sme_datapath #(
      .MAX_PAIRS (MAX_PAIRS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // at most one datapath command per cycle
   `SME_ASSERT_ALW(a_cmd_onehot, clock, reset, $onehot0(cmd))
   // a result word is never loaded over one still waiting
   `SME_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, stat.out_free)
   // after the final word of a run the engine takes requests again
   `SME_ASSERT_NXT(a_done_idle, clock, reset, cmd.out_load && stat.last_seller, !req_stall)

endmodule

[src/sme_datapath.sv]
// preference memories, match state, counters and the result register
module sme_datapath #(
   parameter int MAX_PAIRS = sme_pkg::MAX_PAIRS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sme_pkg::sme_req_type       req_data,
   input  logic                       csr_wr_en,
   input  logic [sme_pkg::CFG_W-1:0]  csr_wr_data,
   input  logic                       rsp_stall,
   input  sme_pkg::sme_cmd_type       cmd,
   output sme_pkg::sme_stat_type      stat,
   output logic                       rsp_valid,
   output sme_pkg::sme_rsp_type       rsp_data
);
   import sme_pkg::*;

   localparam int NP    = (MAX_PAIRS < ID_RANGE) ? MAX_PAIRS : ID_RANGE;
   localparam int IW    = $clog2(NP);
   localparam int NW    = IW + 1;
   localparam int DEPTH = 1 << (2 * IW);

   logic [ID_W-1:0]  pref_mem [DEPTH];
   logic [ID_W-1:0]  rank_mem [DEPTH];
   logic [ID_W-1:0]  pref_q_ff;
   logic [ID_W-1:0]  rank_q_ff;

   logic [CFG_W-1:0] pairs_ff;
   logic [NW-1:0]    n_ff;
   logic [NW-1:0]    n_in;
   logic [IW-1:0]    s_ff;
   logic             proposed_ff;
   logic [NW-1:0]    unmatched_ff;

   logic [NW-1:0]    pos_ff           [NP];
   logic             seller_has_ff    [NP];
   logic [IW-1:0]    seller_partner_ff[NP];
   logic             buyer_has_ff     [NP];
   logic [IW-1:0]    buyer_partner_ff [NP];
   logic [ID_W-1:0]  held_rank_ff     [NP];

   logic             rsp_valid_ff;
   sme_rsp_type      rsp_ff;

   logic             load_ok;
   logic [IW-1:0]    b_idx;
   logic [NW-1:0]    cur_pos;

   // load is ignored when any index is past the built size
   assign load_ok = ((CFG_W)'(req_data.person) < (CFG_W)'(NP)) &&
                    ((CFG_W)'(req_data.position) < (CFG_W)'(NP)) &&
                    ((CFG_W)'(req_data.chosen) < (CFG_W)'(NP));

   always_comb begin
      if (pairs_ff == '0) begin
         n_in = NW'(1);
      end else if (pairs_ff > (CFG_W)'(NP)) begin
         n_in = NW'(NP);
      end else begin
         n_in = NW'(pairs_ff);
      end
   end

   assign b_idx   = pref_q_ff[IW-1:0];
   assign cur_pos = pos_ff[s_ff];

   // seller preference memory
   always_ff @(posedge clock) begin
      if (cmd.load_seller && load_ok) begin
         pref_mem[{req_data.person[IW-1:0], req_data.position[IW-1:0]}] <= req_data.chosen;
      end
      if (cmd.scan) begin
         pref_q_ff <= pref_mem[{s_ff, cur_pos[IW-1:0]}];
      end
   end

   // inverse rank memory, indexed by buyer then seller
   always_ff @(posedge clock) begin
      if (cmd.load_buyer && load_ok) begin
         rank_mem[{req_data.person[IW-1:0], req_data.chosen[IW-1:0]}] <= req_data.position;
      end
      if (cmd.rank_rd) begin
         rank_q_ff <= rank_mem[{b_idx, s_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff <= PAIRS_RESET;
      end else if (csr_wr_en) begin
         pairs_ff <= csr_wr_data;
      end
   end

   // run counters and match state
   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff         <= '0;
         proposed_ff  <= 1'b0;
         unmatched_ff <= '0;
         n_ff         <= NW'(NP);
         for (int i = 0; i < NP; i++) begin
            seller_has_ff[i] <= 1'b0;
            buyer_has_ff[i]  <= 1'b0;
            pos_ff[i]        <= '0;
         end
      end else begin
         if (cmd.run_init) begin
            n_ff         <= n_in;
            unmatched_ff <= n_in;
            s_ff         <= '0;
            proposed_ff  <= 1'b0;
            for (int i = 0; i < NP; i++) begin
               seller_has_ff[i] <= 1'b0;
               buyer_has_ff[i]  <= 1'b0;
               pos_ff[i]        <= '0;
            end
         end
         if (cmd.scan && stat.eligible) begin
            pos_ff[s_ff] <= cur_pos + NW'(1);
            proposed_ff  <= 1'b1;
         end
         if (cmd.decide) begin
            if (!buyer_has_ff[b_idx]) begin
               buyer_has_ff[b_idx]     <= 1'b1;
               buyer_partner_ff[b_idx] <= s_ff;
               held_rank_ff[b_idx]     <= rank_q_ff;
               seller_has_ff[s_ff]     <= 1'b1;
               seller_partner_ff[s_ff] <= b_idx;
               unmatched_ff            <= unmatched_ff - NW'(1);
            end else if (rank_q_ff < held_rank_ff[b_idx]) begin
               // displaced seller freed first, proposer set after
               seller_has_ff[buyer_partner_ff[b_idx]] <= 1'b0;
               buyer_partner_ff[b_idx] <= s_ff;
               held_rank_ff[b_idx]     <= rank_q_ff;
               seller_has_ff[s_ff]     <= 1'b1;
               seller_partner_ff[s_ff] <= b_idx;
            end
         end
         if (cmd.next_seller || cmd.out_load) begin
            s_ff <= s_ff + IW'(1);
         end
         if (cmd.new_round) begin
            s_ff        <= '0;
            proposed_ff <= 1'b0;
         end
         if (cmd.out_start) begin
            s_ff <= '0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.seller_id <= ID_W'(s_ff);
         rsp_ff.buyer_id  <= seller_has_ff[s_ff] ? ID_W'(seller_partner_ff[s_ff]) : '0;
         rsp_ff.last      <= stat.last_seller;
      end
   end

   assign stat.eligible       = !seller_has_ff[s_ff] && (cur_pos < n_ff);
   assign stat.buyer_ok       = (CFG_W)'(pref_q_ff) < (CFG_W)'(n_ff);
   assign stat.unmatched_zero = (unmatched_ff == '0);
   assign stat.last_seller    = (NW'(s_ff) + NW'(1)) == n_ff;
   assign stat.proposed       = proposed_ff;
   assign stat.out_free       = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/sme_ctrl.sv]
// sequencer for loads, proposal rounds and result output
module sme_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_stall,
   input  sme_pkg::sme_stat_type stat,
   output sme_pkg::sme_cmd_type  cmd
);
   import sme_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PREF = 3'd2;
   localparam logic [2:0] ST_RANK = 3'd3;
   localparam logic [2:0] ST_ADV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LOAD_SELLER: cmd.load_seller = 1'b1;
                  CMD_LOAD_BUYER:  cmd.load_buyer  = 1'b1;
                  CMD_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = stat.eligible ? ST_PREF : ST_ADV;
         end
         ST_PREF: begin
            if (stat.buyer_ok) begin
               cmd.rank_rd = 1'b1;
               state_in    = ST_RANK;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_RANK: begin
            cmd.decide = 1'b1;
            state_in   = ST_ADV;
         end
         ST_ADV: begin
            if (stat.unmatched_zero || (stat.last_seller && !stat.proposed)) begin
               cmd.out_start = 1'b1;
               state_in      = ST_OUT;
            end else if (stat.last_seller) begin
               cmd.new_round = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.next_seller = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (stat.last_seller) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[tb/testbench.sv]
// self-checking testbench for the stable matching engine
`timescale 1ns / 1ps

module testbench;
   import sme_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;   // spare command code, ignored by the block
   localparam int SLOTS        = MAX_PAIRS_DEFAULT;
   localparam int PHASES       = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int QUIET_CYCLES = 8;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic             is_cfg;
      logic [CFG_W-1:0] cfg_val;
      sme_req_type      word;
      logic             given;   // pair typed in by hand instead of predicted
      sme_rsp_type      pair;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sme_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sme_rsp_type       rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = '0;

   // predictor state: preference lists, inverted buyer ranks, what has been loaded
   logic [ID_W-1:0]   seller_list [SLOTS][SLOTS];   // seller, position -> buyer
   logic [ID_W-1:0]   buyer_rank  [SLOTS][SLOTS];   // buyer, seller -> rank
   bit                list_loaded [SLOTS][SLOTS];
   bit                rank_loaded [SLOTS][SLOTS];
   logic [CFG_W-1:0]  pairs_cfg = PAIRS_RESET;

   sme_rsp_type       pending_pairs [$];   // pairs still owed by the block, oldest first
   sme_rsp_type       run_pairs [$];       // pairs of the last run word predicted
   plan_row_type      plan_q [$];
   int                deal [SLOTS];        // scratch permutation
   sme_rsp_type       want_pair;

   int                idle_pct = 0;        // chance in percent of starting an idle or stall burst
   int                stall_left = 0;
   int                mismatches = 0;
   int unsigned       cycle_count = 0;

   stable_matching_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // pairs_in_use as the block uses it: clamped to 1 .. built size
   function automatic int active_pairs();
      int n;
      n = int'(pairs_cfg);
      if (n < 1) n = 1;
      if (n > SLOTS) n = SLOTS;
      return n;
   endfunction

   // seller-proposing rounds over the loaded tables, one pair per seller into run_pairs
   function automatic void solve_matching();
      int n, s, pos, b, r, prev, free_cnt;
      bit progress;
      int next_pos [SLOTS];
      bit s_held [SLOTS];
      bit b_held [SLOTS];
      int s_mate [SLOTS];
      int b_mate [SLOTS];
      int b_rank [SLOTS];
      sme_rsp_type pair;
      n = active_pairs();
      for (s = 0; s < SLOTS; s++) begin
         next_pos[s] = 0;
         s_held[s]   = 1'b0;
         b_held[s]   = 1'b0;
         s_mate[s]   = 0;
         b_mate[s]   = 0;
         b_rank[s]   = 0;
      end
      free_cnt = n;
      do begin
         progress = 1'b0;
         for (s = 0; s < n && free_cnt > 0; s++) begin
            // matched sellers and sellers out of list sit the round out
            if (s_held[s] || next_pos[s] >= n) continue;
            pos = next_pos[s];
            progress = 1'b1;
            b = int'(seller_list[s][pos]);
            next_pos[s] = pos + 1;
            // buyer beyond the pairs in use turns every proposal down
            if (b >= n) continue;
            r = int'(buyer_rank[b][s]);
            if (!b_held[b]) begin
               b_held[b] = 1'b1;
               b_mate[b] = s;
               b_rank[b] = r;
               s_held[s] = 1'b1;
               s_mate[s] = b;
               free_cnt--;
            end else if (r < b_rank[b]) begin
               // strictly better seller displaces the held one; a tie keeps it
               prev = b_mate[b];
               s_held[prev] = 1'b0;
               b_mate[b] = s;
               b_rank[b] = r;
               s_held[s] = 1'b1;
               s_mate[s] = b;
            end
         end
      end while (free_cnt > 0 && progress);
      for (s = 0; s < n; s++) begin
         pair.seller_id = ID_W'(s);
         pair.buyer_id  = ID_W'(s_held[s] ? s_mate[s] : 0);   // unmatched seller reports buyer 0
         pair.last      = (s == n - 1);
         run_pairs.push_back(pair);
      end
   endfunction

   function automatic void apply_word(input sme_req_type w);
      run_pairs.delete();
      case (w.cmd)
         CMD_LOAD_SELLER: begin
            seller_list[w.person][w.position] = w.chosen;
            list_loaded[w.person][w.position] = 1'b1;
         end
         CMD_LOAD_BUYER: begin
            // buyer entries are kept inverted: rank of the chosen seller
            buyer_rank[w.person][w.chosen]  = w.position;
            rank_loaded[w.person][w.chosen] = 1'b1;
         end
         CMD_RUN: solve_matching();
         default: ;
      endcase
   endfunction

   function automatic void add_cfg(input logic [CFG_W-1:0] v);
      plan_row_type row;
      row = '0;
      row.is_cfg  = 1'b1;
      row.cfg_val = v;
      plan_q.push_back(row);
   endfunction

   function automatic void add_word(input logic [1:0] cmd, input logic [ID_W-1:0] p,
                                    input logic [ID_W-1:0] q, input logic [ID_W-1:0] c);
      plan_row_type row;
      row = '0;
      row.word = {cmd, p, q, c};
      plan_q.push_back(row);
   endfunction

   // run word of a one-pair setting, with its single pair typed in
   function automatic void add_run_typed(input logic [ID_W-1:0] sid,
                                         input logic [ID_W-1:0] bid);
      plan_row_type row;
      row = '0;
      row.word.cmd       = CMD_RUN;
      row.given          = 1'b1;
      row.pair.seller_id = sid;
      row.pair.buyer_id  = bid;
      row.pair.last      = 1'b1;
      plan_q.push_back(row);
   endfunction

   function automatic void shuffle_deal(input int n);
      int k, j, t;
      for (k = 0; k < n; k++) deal[k] = k;
      for (k = n - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = deal[k];
         deal[k] = deal[j];
         deal[j] = t;
      end
   endfunction

   // one request word: optional idle burst, hold until taken, then predict
   task automatic send_word(input sme_req_type w, input bit typed,
                            input sme_rsp_type typed_pair);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      apply_word(w);
      if (typed) pending_pairs.push_back(typed_pair);
      else foreach (run_pairs[i]) pending_pairs.push_back(run_pairs[i]);
   endtask

   // table load with the odd ignored word thrown in as noise
   task automatic send_load(input logic [1:0] cmd, input logic [ID_W-1:0] p,
                            input logic [ID_W-1:0] q, input logic [ID_W-1:0] c);
      logic [3*ID_W-1:0] junk;
      if ($urandom_range(0, 11) == 0) begin
         junk = (3*ID_W)'($urandom);
         send_word({CMD_UNUSED, junk}, 1'b0, '0);
      end
      send_word({cmd, p, q, c}, 1'b0, '0);
   endtask

   task automatic write_cfg(input logic [CFG_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pairs_cfg = v;
   endtask

   // all pairs back, then a quiet wait for the last loads to land
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // every entry a run over n pairs could read must hold a loaded value
   task automatic cover_tables(input int n);
      int a, k;
      for (a = 0; a < n; a++) begin
         for (k = 0; k < n; k++) begin
            if (!list_loaded[a][k])
               send_load(CMD_LOAD_SELLER, ID_W'(a), ID_W'(k),
                         ID_W'($urandom_range(0, SLOTS - 1)));
            if (!rank_loaded[a][k])
               send_load(CMD_LOAD_BUYER, ID_W'(a), ID_W'($urandom_range(0, n - 1)),
                         ID_W'(k));
         end
      end
   endtask

   // full lists for n sellers and n buyers: permutations, or random with
   // out-of-range buyers, repeats and rank ties when not well formed
   task automatic load_lists(input int n, input bit wellformed);
      int a, k;
      for (a = 0; a < n; a++) begin
         shuffle_deal(n);
         for (k = 0; k < n; k++)
            send_load(CMD_LOAD_SELLER, ID_W'(a), ID_W'(k),
                      ID_W'(wellformed ? deal[k] : $urandom_range(0, SLOTS - 1)));
         shuffle_deal(n);
         for (k = 0; k < n; k++)
            send_load(CMD_LOAD_BUYER, ID_W'(a),
                      ID_W'(wellformed ? k : $urandom_range(0, n - 1)), ID_W'(deal[k]));
      end
   endtask

   // full size with every seller's first choice a different buyer: one round
   // matches everyone, so only first entries and their ranks are read
   task automatic spread_lists();
      int a;
      shuffle_deal(SLOTS);
      for (a = 0; a < SLOTS; a++) begin
         send_load(CMD_LOAD_SELLER, ID_W'(a), '0, ID_W'(deal[a]));
         send_load(CMD_LOAD_BUYER, ID_W'(deal[a]), ID_W'($urandom_range(0, SLOTS - 1)),
                   ID_W'(a));
      end
   endtask

   // a few scattered entry rewrites between runs
   task automatic edit_some(input int n);
      int k, count;
      count = $urandom_range(1, 3);
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 1) == 0)
            send_load(CMD_LOAD_SELLER, ID_W'($urandom_range(0, n - 1)),
                      ID_W'($urandom_range(0, n - 1)), ID_W'($urandom_range(0, SLOTS - 1)));
         else
            send_load(CMD_LOAD_BUYER, ID_W'($urandom_range(0, n - 1)),
                      ID_W'($urandom_range(0, n - 1)), ID_W'($urandom_range(0, n - 1)));
      end
   endtask

   // result side: compare each accepted pair, then drive back-pressure in bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("pair with nothing pending: seller %0d buyer %0d last %0d",
                        rsp_data.seller_id, rsp_data.buyer_id, rsp_data.last);
         end else begin
            want_pair = pending_pairs.pop_front();
            if (rsp_data.seller_id !== want_pair.seller_id ||
                rsp_data.buyer_id !== want_pair.buyer_id ||
                rsp_data.last !== want_pair.last) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("pair mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           want_pair.seller_id, want_pair.buyer_id, want_pair.last,
                           rsp_data.seller_id, rsp_data.buyer_id, rsp_data.last);
            end
         end
      end
      if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
         stall_left = $urandom_range(1, 7);
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      int ph, n, k, runs, pick;
      bit fresh;
      logic [CFG_W-1:0] cfg_v;
      logic [3*ID_W-1:0] fill;

      // one pair, trivial lists
      add_cfg(5'd1);
      add_word(CMD_LOAD_SELLER, 4'd0, 4'd0, 4'd0);
      add_word(CMD_LOAD_BUYER, 4'd0, 4'd0, 4'd0);
      add_run_typed(4'd0, 4'd0);
      // ignored command and loads at the top corner of the tables
      add_word(CMD_UNUSED, 4'd15, 4'd15, 4'd15);
      add_word(CMD_LOAD_SELLER, 4'd15, 4'd15, 4'd15);
      add_word(CMD_LOAD_BUYER, 4'd15, 4'd15, 4'd15);
      // zero in the register clamps to one pair
      add_cfg(5'd0);
      add_run_typed(4'd0, 4'd0);
      // two pairs: seller 0 first names a buyer out of range, then ties with
      // seller 1 at buyer 1 and loses, runs out of list and is left unmatched
      add_cfg(5'd2);
      add_word(CMD_LOAD_SELLER, 4'd0, 4'd0, 4'd5);
      add_word(CMD_LOAD_SELLER, 4'd0, 4'd1, 4'd1);
      add_word(CMD_LOAD_SELLER, 4'd1, 4'd0, 4'd1);
      add_word(CMD_LOAD_SELLER, 4'd1, 4'd1, 4'd0);
      add_word(CMD_LOAD_BUYER, 4'd1, 4'd0, 4'd0);
      add_word(CMD_LOAD_BUYER, 4'd1, 4'd0, 4'd1);
      add_word(CMD_LOAD_BUYER, 4'd0, 4'd0, 4'd0);
      add_word(CMD_LOAD_BUYER, 4'd0, 4'd1, 4'd1);
      add_word(CMD_RUN, 4'd0, 4'd0, 4'd0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 20;
      foreach (plan_q[i]) begin
         if (plan_q[i].is_cfg) begin
            wait_quiet();
            write_cfg(plan_q[i].cfg_val);
         end else begin
            send_word(plan_q[i].word, plan_q[i].given, plan_q[i].pair);
         end
      end

      // random phases: mostly small sizes, then full size and settings above
      // the built size that clamp to it; the last phases run flat out
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            6:       cfg_v = 5'd16;
            7:       cfg_v = 5'd31;
            9:       cfg_v = CFG_W'($urandom_range(17, 30));
            default: cfg_v = CFG_W'($urandom_range(0, 7));
         endcase
         wait_quiet();
         write_cfg(cfg_v);
         n = active_pairs();
         idle_pct = (ph >= PHASES - 2) ? 0 : 10 * $urandom_range(0, 3);
         pick = $urandom_range(0, 9);
         fresh = 1'b1;
         if (n < SLOTS && pick < 6) load_lists(n, 1'b1);
         else if (n < SLOTS && pick < 8) load_lists(n, 1'b0);
         else fresh = 1'b0;
         runs = $urandom_range(1, 3);
         for (k = 0; k < runs; k++) begin
            if (n == SLOTS) begin
               if (k == 0) spread_lists();
            end else begin
               if (k != 0 || !fresh) edit_some(n);
               cover_tables(n);
            end
            fill = (3*ID_W)'($urandom);
            send_word({CMD_RUN, fill}, 1'b0, '0);
         end
      end

      wait_quiet();
      if (mismatches == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/sme_pkg.sv
src/sme_datapath.sv
src/sme_ctrl.sv
src/stable_matching_engine.sv
tb/testbench.sv
